[src/sft_pkg.sv]
package sft_pkg;

	typedef enum logic [2:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_CONFLICT  = 3'd2,
		ST_FULL      = 3'd3,
		ST_FOUND     = 3'd4,
		ST_NOTFOUND  = 3'd5,
		ST_CLEARED   = 3'd6
	} status_t;

	localparam logic [1:0] KIND_INSERT = 2'd0;
	localparam logic [1:0] KIND_FIND   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT
	} state_t;

	// broadcast controls from the sequencer to every cell
	typedef struct packed {
		logic tok_clr;
		logic write_en;
	} cell_ctl_t;

endpackage

[src/sft_cell.sv]
module sft_cell import sft_pkg::*; #(
	parameter int ID_BITS    = 24,
	parameter int VALUE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cell_ctl_t             ctl,
	input  logic                  occupied,
	input  logic                  slot,
	input  logic [ID_BITS-1:0]    key,
	input  logic [VALUE_BITS-1:0] key_value,
	input  logic [ID_BITS-1:0]    prev_id,
	input  logic [VALUE_BITS-1:0] prev_value,
	input  logic                  prev_lt,
	input  logic                  prev_hit,
	input  logic [VALUE_BITS-1:0] prev_tok_value,
	output logic [ID_BITS-1:0]    id,
	output logic [VALUE_BITS-1:0] value,
	output logic                  lt,
	output logic                  hit,
	output logic [VALUE_BITS-1:0] tok_value
);

	logic [ID_BITS-1:0]    id_q;
	logic [VALUE_BITS-1:0] value_q;
	logic                  hit_q;
	logic [VALUE_BITS-1:0] tok_value_q;
	logic                  eq;

	assign lt = occupied && (id_q < key);
	assign eq = occupied && (id_q == key);

	// entries at or above the insert point move up one place
	always_ff @(posedge clk) begin
		if (ctl.write_en && slot && !lt) begin
			if (prev_lt) begin
				id_q    <= key;
				value_q <= key_value;
			end else begin
				id_q    <= prev_id;
				value_q <= prev_value;
			end
		end
	end

	// match token ripples one cell per cycle towards the end of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (ctl.tok_clr) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= prev_hit | eq;
		end
	end

	always_ff @(posedge clk) begin
		tok_value_q <= prev_hit ? prev_tok_value : value_q;
	end

	assign id        = id_q;
	assign value     = value_q;
	assign hit       = hit_q;
	assign tok_value = tok_value_q;

endmodule

[src/sorted_feature_table_core.sv]
// items are taken one at a time: in_ready is high only while idle, and each item
// waits for the match token rippling through the row of CAPACITY cells before
// the result is decided
// a finished result waits in the output register while the next item scans
// reset (arst_n low) empties the table and clears control; stored entries are undefined
module sorted_feature_table_core import sft_pkg::*; #(
	parameter int CAPACITY   = 64,
	parameter int ID_BITS    = 24,
	parameter int VALUE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    kind,
	input  logic [ID_BITS-1:0]            entry_id,
	input  logic [VALUE_BITS-1:0]         entry_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [2:0]                    status,
	output logic [VALUE_BITS-1:0]         found_value,
	output logic [$clog2(CAPACITY+1)-1:0] fill_count
);

	localparam int CW  = $clog2(CAPACITY + 1);
	localparam int SCW = $clog2(CAPACITY);

	state_t state_q, state_d;
	logic [SCW-1:0]        scan_q;
	logic [CW-1:0]         count_q, count_d;
	logic [1:0]            kind_q;
	logic [ID_BITS-1:0]    key_q;
	logic [VALUE_BITS-1:0] key_value_q;

	logic                  out_valid_q;
	status_t               status_q, status_d;
	logic [VALUE_BITS-1:0] found_value_q, found_value_d;
	logic [CW-1:0]         fill_count_q;

	cell_ctl_t ctl;
	logic      load_out;
	logic      in_xfer;

	logic [ID_BITS-1:0]    id_w     [CAPACITY];
	logic [VALUE_BITS-1:0] value_w  [CAPACITY];
	logic                  lt_w     [CAPACITY];
	logic                  hit_w    [CAPACITY];
	logic [VALUE_BITS-1:0] tokval_w [CAPACITY];

	assign in_ready = (state_q == S_IDLE);
	assign in_xfer  = in_valid && in_ready;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam logic [CW-1:0] IDX = CW'(i);
		logic                  p_lt, p_hit;
		logic [ID_BITS-1:0]    p_id;
		logic [VALUE_BITS-1:0] p_value, p_tokval;

		if (i == 0) begin : g_head
			assign p_lt     = 1'b1;
			assign p_hit    = 1'b0;
			assign p_id     = '0;
			assign p_value  = '0;
			assign p_tokval = '0;
		end else begin : g_body
			assign p_lt     = lt_w[i-1];
			assign p_hit    = hit_w[i-1];
			assign p_id     = id_w[i-1];
			assign p_value  = value_w[i-1];
			assign p_tokval = tokval_w[i-1];
		end

		sft_cell #(
			.ID_BITS   (ID_BITS),
			.VALUE_BITS(VALUE_BITS)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctl           (ctl),
			.occupied      (IDX < count_q),
			.slot          (IDX <= count_q),
			.key           (key_q),
			.key_value     (key_value_q),
			.prev_id       (p_id),
			.prev_value    (p_value),
			.prev_lt       (p_lt),
			.prev_hit      (p_hit),
			.prev_tok_value(p_tokval),
			.id            (id_w[i]),
			.value         (value_w[i]),
			.lt            (lt_w[i]),
			.hit           (hit_w[i]),
			.tok_value     (tokval_w[i])
		);
	end

	always_comb begin
		logic                  hit;
		logic [VALUE_BITS-1:0] hv;
		hit           = hit_w[CAPACITY-1];
		hv            = tokval_w[CAPACITY-1];
		state_d       = state_q;
		count_d       = count_q;
		status_d      = ST_NOTFOUND;
		found_value_d = '0;
		ctl.tok_clr   = in_xfer;
		ctl.write_en  = 1'b0;
		load_out      = 1'b0;

		case (kind_q)
			KIND_INSERT: begin
				if (hit) begin
					status_d = (hv == key_value_q) ? ST_DUPLICATE : ST_CONFLICT;
				end else if (count_q == CW'(CAPACITY)) begin
					status_d = ST_FULL;
				end else begin
					status_d = ST_INSERTED;
				end
			end
			KIND_FIND: begin
				if (hit) begin
					status_d      = ST_FOUND;
					found_value_d = hv;
				end
			end
			KIND_CLEAR: status_d = ST_CLEARED;
			default: status_d = ST_NOTFOUND;
		endcase

		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_q == SCW'(CAPACITY - 1)) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
					if (status_d == ST_INSERTED) begin
						ctl.write_en = 1'b1;
						count_d      = count_q + 1'b1;
					end else if (status_d == ST_CLEARED) begin
						count_d = '0;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			scan_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (in_xfer) begin
				scan_q <= '0;
			end else if (state_q == S_SCAN) begin
				scan_q <= scan_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			kind_q      <= kind;
			key_q       <= entry_id;
			key_value_q <= entry_value;
		end
		if (load_out) begin
			status_q      <= status_d;
			found_value_q <= found_value_d;
			fill_count_q  <= count_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_value = found_value_q;
	assign fill_count  = fill_count_q;

`ifndef NO_ASSERTIONS
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.write_en |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not grow the table by one");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_accept_scans: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> state_q == S_SCAN && scan_q == '0)
		else $error("accepted item did not start a scan");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != ST_FOUND |-> found_value_q == '0)
		else $error("found_value not zero for a miss");
`endif

endmodule
